// File: hdl/lgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the LED grayscale serializer.
// ---------------------------------------------------------------------------
package lgs_pkg;

  localparam int STORE_WORDS_DEF = 64;
  localparam int LEVEL_BITS_DEF  = 12;
  localparam int GRAY_PULSES_DEF = 4096;

  localparam int CHANNELS       = 16;
  localparam int WORDS_PER_CHAN = 4;
  localparam int WORDS_PER_DRV  = 16;
  localparam int DC_BITS        = 96;
  localparam int DRV_RESET      = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_DOTC  = 2'd3
  } cmd_t;

  typedef enum logic [15:0] {
    P_IDLE    = 16'h0001,
    P_W_START = 16'h0002,
    P_W_SLO   = 16'h0004,
    P_W_SHI   = 16'h0008,
    P_W_CEND  = 16'h0010,
    P_W_LHI   = 16'h0020,
    P_W_LLO   = 16'h0040,
    P_W_BHI   = 16'h0080,
    P_W_GHI   = 16'h0100,
    P_W_GLO   = 16'h0200,
    P_D_SLO   = 16'h0400,
    P_D_SHI   = 16'h0800,
    P_D_LHI   = 16'h1000,
    P_D_LLO   = 16'h2000,
    P_D_CHI   = 16'h4000,
    P_D_CLO   = 16'h8000
  } phase_t;

  typedef struct packed {
    logic gck;
    logic blk;
    logic mode;
    logic lat;
    logic dat;
    logic sclk;
  } pins_t;

  typedef struct packed {
    logic  busy;
    logic  busy_nxt;
    pins_t pins;
    pins_t pins_nxt;
  } seq_stat_t;

endpackage
`default_nettype wire

// File: hdl/lgs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lgs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hdl/lgs_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lgs_seq
// Pin sequencer: phase, word/bit/pulse counters and pin levels, one step
// per transaction. Issues the level store read for the word it shifts next.
// ---------------------------------------------------------------------------
module lgs_seq
  import lgs_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
  parameter int GRAY_PULSES = GRAY_PULSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  cmd_t                             cmd,
  input  logic [2:0]                       drivers,
  input  logic [LEVEL_BITS-1:0]            rd_level,
  output logic [$clog2(STORE_WORDS)-3:0]   rd_row,
  output seq_stat_t                        stat
);

  localparam int WORD_W = $clog2(STORE_WORDS);
  localparam int BIT_W  = $clog2(DC_BITS + 1);
  localparam int BSEL_W = $clog2(LEVEL_BITS);
  localparam int GCNT_W = $clog2(GRAY_PULSES + 1);

  phase_t              phase_r, phase_nxt, eff;
  logic [WORD_W-1:0]   word_r, word_nxt, start_word;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [GCNT_W-1:0]   gcnt_r, gcnt_nxt;
  pins_t               pins_r, pins_nxt;
  logic                start_wr, start_dc;

  assign start_wr   = (phase_r == P_IDLE) && (cmd == CMD_WRITE);
  assign start_dc   = (phase_r == P_IDLE) && (cmd == CMD_DOTC);
  assign start_word = WORD_W'(int'(drivers) * WORDS_PER_DRV - 1);

  always_comb begin
    eff       = start_wr ? P_W_START : (start_dc ? P_D_SLO : phase_r);
    phase_nxt = phase_r;
    word_nxt  = word_r;
    bit_nxt   = start_dc ? '0 : bit_r;
    gcnt_nxt  = gcnt_r;
    pins_nxt  = pins_r;
    case (eff)
      P_W_START: begin
        pins_nxt.blk = 1'b0;
        pins_nxt.lat = 1'b0;
        word_nxt     = start_word;
        bit_nxt      = BIT_W'(LEVEL_BITS - 1);
        phase_nxt    = P_W_SLO;
      end
      P_W_SLO: begin
        pins_nxt.sclk = 1'b0;
        pins_nxt.dat  = rd_level[bit_r[BSEL_W-1:0]];
        phase_nxt     = P_W_SHI;
      end
      P_W_SHI: begin
        pins_nxt.sclk = 1'b1;
        if (bit_r != '0) begin
          bit_nxt   = bit_r - 1'b1;
          phase_nxt = P_W_SLO;
        end else if (word_r != '0) begin
          word_nxt  = word_r - 1'b1;
          bit_nxt   = BIT_W'(LEVEL_BITS - 1);
          phase_nxt = P_W_SLO;
        end else begin
          phase_nxt = P_W_CEND;
        end
      end
      P_W_CEND: begin
        pins_nxt.sclk = 1'b0;
        phase_nxt     = P_W_LHI;
      end
      P_W_LHI: begin
        pins_nxt.lat = 1'b1;
        phase_nxt    = P_W_LLO;
      end
      P_W_LLO: begin
        pins_nxt.lat = 1'b0;
        phase_nxt    = P_W_BHI;
      end
      P_W_BHI: begin
        pins_nxt.blk = 1'b1;
        gcnt_nxt     = '0;
        phase_nxt    = P_W_GHI;
      end
      P_W_GHI: begin
        pins_nxt.gck = 1'b1;
        phase_nxt    = P_W_GLO;
      end
      P_W_GLO: begin
        pins_nxt.gck = 1'b0;
        gcnt_nxt     = gcnt_r + 1'b1;
        phase_nxt    = (gcnt_nxt >= GCNT_W'(GRAY_PULSES)) ? P_IDLE : P_W_GHI;
      end
      P_D_SLO: begin
        pins_nxt.lat  = 1'b0;
        pins_nxt.mode = 1'b1;
        pins_nxt.sclk = 1'b0;
        pins_nxt.dat  = 1'b1;
        phase_nxt     = P_D_SHI;
      end
      P_D_SHI: begin
        pins_nxt.sclk = 1'b1;
        bit_nxt       = bit_r + 1'b1;
        phase_nxt     = (bit_nxt >= BIT_W'(DC_BITS)) ? P_D_LHI : P_D_SLO;
      end
      P_D_LHI: begin
        pins_nxt.lat = 1'b1;
        phase_nxt    = P_D_LLO;
      end
      P_D_LLO: begin
        pins_nxt.lat = 1'b0;
        phase_nxt    = P_D_CHI;
      end
      P_D_CHI: begin
        pins_nxt.sclk = 1'b1;
        phase_nxt     = P_D_CLO;
      end
      P_D_CLO: begin
        pins_nxt.sclk = 1'b0;
        phase_nxt     = P_IDLE;
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      word_r  <= '0;
      bit_r   <= '0;
      gcnt_r  <= '0;
      pins_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      word_r  <= word_nxt;
      bit_r   <= bit_nxt;
      gcnt_r  <= gcnt_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // four words of a channel share one store row
  assign rd_row = word_nxt[WORD_W-1:2];

  assign stat.busy     = (phase_r != P_IDLE);
  assign stat.busy_nxt = (phase_nxt != P_IDLE);
  assign stat.pins     = pins_r;
  assign stat.pins_nxt = pins_nxt;

endmodule
`default_nettype wire

// File: hdl/led_grayscale_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// led_grayscale_serializer
// Tick-driven pin sequencer for chained 16-channel LED PWM drivers.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  in_cmd, in_channel, in_level
//   out      out_valid/out_stall pin levels, out_busy_res, out_rejected
//   cfg      cfg_valid/cfg_ready cfg_data (driver count)
//
// One transaction per cycle while in_stall is low; each produces one result
// in the next cycle through the output register. The level store row for the next shifted
// word is read on every transaction, so the registered RAM read data is ready
// for the following step. Reset clears per-row valid bits at once; there is
// no clearing pass. in_stall is high only while a result waits under
// out_stall.
// ---------------------------------------------------------------------------
module led_grayscale_serializer
  import lgs_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
  parameter int GRAY_PULSES = GRAY_PULSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_channel,
  input  logic [15:0] in_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_serial_clock,
  output logic        out_serial_data,
  output logic        out_latch_pin,
  output logic        out_mode_pin,
  output logic        out_blank_pin,
  output logic        out_gray_clock,
  output logic        out_busy_res,
  output logic        out_rejected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  localparam int ROWS      = (STORE_WORDS + WORDS_PER_CHAN - 1) / WORDS_PER_CHAN;
  localparam int ROW_W     = $clog2(STORE_WORDS) - 2;
  localparam int MAX_DRV   = STORE_WORDS / WORDS_PER_DRV;
  localparam int LEVEL_TOP = (1 << LEVEL_BITS) - 1;

  logic [2:0]            drv_cfg_r, drivers;
  logic                  accept, chan_ok, set_we, reject;
  cmd_t                  cmd;
  logic [ROW_W-1:0]      wr_row, rd_row;
  logic [LEVEL_BITS-1:0] wr_level, rd_data, rd_level;
  logic [ROWS-1:0]       vld_r;
  logic                  rd_vld_r;
  logic                  out_valid_r;
  pins_t                 out_pins_r;
  logic                  out_busy_r, out_rej_r;
  seq_stat_t             stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_cfg_r <= 3'(DRV_RESET);
    end else if (cfg_valid && cfg_ready) begin
      drv_cfg_r <= cfg_data;
    end
  end

  always_comb begin
    drivers = drv_cfg_r;
    if (drv_cfg_r == 3'd0) begin
      drivers = 3'd1;
    end else if (int'(drv_cfg_r) > MAX_DRV) begin
      drivers = 3'(MAX_DRV);
    end
  end

  assign cmd      = cmd_t'(in_cmd);
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign chan_ok  = (in_channel != 8'd0) && (in_channel <= 8'(CHANNELS)) &&
                    (int'(in_channel) * WORDS_PER_CHAN <= STORE_WORDS);
  assign set_we   = accept && !stat.busy && (cmd == CMD_SET) && chan_ok;
  assign wr_row   = ROW_W'(in_channel - 8'd1);
  assign wr_level = (int'(in_level) > LEVEL_TOP) ? LEVEL_BITS'(LEVEL_TOP)
                                                 : in_level[LEVEL_BITS-1:0];
  assign reject   = stat.busy ? (cmd != CMD_TICK) : ((cmd == CMD_SET) && !chan_ok);

  lgs_ram #(
    .WIDTH (LEVEL_BITS),
    .DEPTH (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (set_we),
    .waddr (wr_row),
    .wdata (wr_level),
    .re    (accept),
    .raddr (rd_row),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (set_we) begin
        vld_r[wr_row] <= 1'b1;
      end
      if (accept) begin
        rd_vld_r <= vld_r[rd_row];
      end
    end
  end

  assign rd_level = rd_vld_r ? rd_data : '0;

  lgs_seq #(
    .STORE_WORDS (STORE_WORDS),
    .LEVEL_BITS  (LEVEL_BITS),
    .GRAY_PULSES (GRAY_PULSES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .cmd      (cmd),
    .drivers  (drivers),
    .rd_level (rd_level),
    .rd_row   (rd_row),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pins_r <= stat.pins_nxt;
      out_busy_r <= stat.busy_nxt;
      out_rej_r  <= reject;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_serial_clock = out_pins_r.sclk;
  assign out_serial_data  = out_pins_r.dat;
  assign out_latch_pin    = out_pins_r.lat;
  assign out_mode_pin     = out_pins_r.mode;
  assign out_blank_pin    = out_pins_r.blk;
  assign out_gray_clock   = out_pins_r.gck;
  assign out_busy_res     = out_busy_r;
  assign out_rejected     = out_rej_r;

`ifndef NO_ASSERTIONS
  a_mode_sticky: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && $past(stat.pins.mode)) |-> stat.pins.mode)
    else $error("mode pin dropped outside reset");

  a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stat.busy && (cmd != CMD_TICK)) |=> out_rejected)
    else $error("command during sequence not rejected");

  a_gck_blank: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pins.gck |-> stat.pins.blk)
    else $error("grayscale clock high while blank low");
`endif

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for led_grayscale_serializer. A short directed table
// covers reset state, channel range, level saturation, frame and dot
// correction sequences and busy rejection. Random command streams with
// random gaps and output stalls follow. Every result transaction is checked
// against an in-bench pin sequencer model, or against the table's typed result.
// ---------------------------------------------------------------------------
module tb_top;
  import lgs_pkg::*;

  localparam int N_WORDS     = STORE_WORDS_DEF;
  localparam int LVL_BITS    = LEVEL_BITS_DEF;
  localparam int N_GRAY      = GRAY_PULSES_DEF;
  localparam int LVL_TOP     = (1 << LVL_BITS) - 1;
  localparam int N_RAND      = 1900;
  localparam int RAND_WRITES = 10;

  typedef struct packed {
    logic  rejected;
    logic  busy;
    pins_t pins;
  } pin_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_DRAIN} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [7:0]  chan;
    logic [15:0] lvl;
    bit          typed;
    pin_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_t        in_cmd = CMD_TICK;
  logic [7:0]  in_channel = '0;
  logic [15:0] in_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_serial_clock;
  logic        out_serial_data;
  logic        out_latch_pin;
  logic        out_mode_pin;
  logic        out_blank_pin;
  logic        out_gray_clock;
  logic        out_busy_res;
  logic        out_rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;

  // model state
  logic [LVL_BITS-1:0] lvl_store [N_WORDS];
  phase_t              seq_phase;
  int unsigned         word_idx;
  int unsigned         bit_idx;
  int unsigned         gray_cnt;
  pins_t               pin_state;
  logic [2:0]          drv_cfg;

  pin_result_t pin_expect_q [$];
  pin_result_t got_res;
  pin_result_t exp_res;
  pin_result_t typed_res;
  bit          typed_on = 1'b0;
  int          err_count = 0;
  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int          stall_roll;
  stim_row_t   stim_table [$];

  led_grayscale_serializer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_channel       (in_channel),
    .in_level         (in_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_serial_clock (out_serial_clock),
    .out_serial_data  (out_serial_data),
    .out_latch_pin    (out_latch_pin),
    .out_mode_pin     (out_mode_pin),
    .out_blank_pin    (out_blank_pin),
    .out_gray_clock   (out_gray_clock),
    .out_busy_res     (out_busy_res),
    .out_rejected     (out_rejected),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------- model ----------------
  function automatic int unsigned chain_len();
    int unsigned n;
    n = drv_cfg;
    if (n < 1) n = 1;
    if (n > N_WORDS / WORDS_PER_DRV) n = N_WORDS / WORDS_PER_DRV;
    return n;
  endfunction

  function automatic void seq_step();
    case (seq_phase)
      P_W_START: begin
        pin_state.blk = 1'b0;
        pin_state.lat = 1'b0;
        word_idx = chain_len() * WORDS_PER_DRV - 1;
        bit_idx = LVL_BITS - 1;
        seq_phase = P_W_SLO;
      end
      P_W_SLO: begin
        pin_state.sclk = 1'b0;
        pin_state.dat = lvl_store[word_idx % N_WORDS][bit_idx % 16];
        seq_phase = P_W_SHI;
      end
      P_W_SHI: begin
        pin_state.sclk = 1'b1;
        if (bit_idx > 0) begin
          bit_idx--;
          seq_phase = P_W_SLO;
        end else if (word_idx > 0) begin
          word_idx--;
          bit_idx = LVL_BITS - 1;
          seq_phase = P_W_SLO;
        end else begin
          seq_phase = P_W_CEND;
        end
      end
      P_W_CEND: begin
        pin_state.sclk = 1'b0;
        seq_phase = P_W_LHI;
      end
      P_W_LHI: begin
        pin_state.lat = 1'b1;
        seq_phase = P_W_LLO;
      end
      P_W_LLO: begin
        pin_state.lat = 1'b0;
        seq_phase = P_W_BHI;
      end
      P_W_BHI: begin
        pin_state.blk = 1'b1;
        gray_cnt = 0;
        seq_phase = P_W_GHI;
      end
      P_W_GHI: begin
        pin_state.gck = 1'b1;
        seq_phase = P_W_GLO;
      end
      P_W_GLO: begin
        pin_state.gck = 1'b0;
        gray_cnt++;
        seq_phase = (gray_cnt >= N_GRAY) ? P_IDLE : P_W_GHI;
      end
      P_D_SLO: begin
        pin_state.lat = 1'b0;
        pin_state.mode = 1'b1;
        pin_state.sclk = 1'b0;
        pin_state.dat = 1'b1;
        seq_phase = P_D_SHI;
      end
      P_D_SHI: begin
        pin_state.sclk = 1'b1;
        bit_idx++;
        seq_phase = (bit_idx >= DC_BITS) ? P_D_LHI : P_D_SLO;
      end
      P_D_LHI: begin
        pin_state.lat = 1'b1;
        seq_phase = P_D_LLO;
      end
      P_D_LLO: begin
        pin_state.lat = 1'b0;
        seq_phase = P_D_CHI;
      end
      P_D_CHI: begin
        pin_state.sclk = 1'b1;
        seq_phase = P_D_CLO;
      end
      P_D_CLO: begin
        pin_state.sclk = 1'b0;
        seq_phase = P_IDLE;
      end
      default: seq_phase = P_IDLE;
    endcase
  endfunction

  function automatic pin_result_t predict_pins(cmd_t c, logic [7:0] ch, logic [15:0] lv);
    pin_result_t r;
    int unsigned base;
    int unsigned sat;
    bit          rej;
    rej = 1'b0;
    if (seq_phase != P_IDLE) begin
      if (c != CMD_TICK) rej = 1'b1;
      seq_step();
    end else if (c == CMD_SET) begin
      base = (32'(ch) - 1) * WORDS_PER_CHAN;
      sat = (lv > LVL_TOP) ? LVL_TOP : lv;
      if (ch < 1 || ch > CHANNELS || ch > chain_len() * WORDS_PER_DRV ||
          base + 3 >= N_WORDS) begin
        rej = 1'b1;
      end else begin
        for (int k = 0; k < WORDS_PER_CHAN; k++) lvl_store[base + k] = sat[LVL_BITS-1:0];
      end
    end else if (c == CMD_WRITE) begin
      seq_phase = P_W_START;
      seq_step();
    end else if (c == CMD_DOTC) begin
      bit_idx = 0;
      seq_phase = P_D_SLO;
      seq_step();
    end
    r.pins = pin_state;
    r.busy = (seq_phase != P_IDLE);
    r.rejected = rej;
    return r;
  endfunction

  function automatic string res_str(pin_result_t r);
    return $sformatf("sclk=%b dat=%b lat=%b mode=%b blk=%b gck=%b busy=%b rej=%b",
                     r.pins.sclk, r.pins.dat, r.pins.lat, r.pins.mode, r.pins.blk,
                     r.pins.gck, r.busy, r.rejected);
  endfunction

  // ---------------- prediction and checking ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) drv_cfg = cfg_data;
      if (in_valid && !in_stall) begin
        exp_res = predict_pins(in_cmd, in_channel, in_level);
        if (typed_on) exp_res = typed_res;
        pin_expect_q.push_back(exp_res);
      end
      if (out_valid && !out_stall) begin
        got_res = {out_rejected, out_busy_res, out_gray_clock, out_blank_pin,
                   out_mode_pin, out_latch_pin, out_serial_data, out_serial_clock};
        if (pin_expect_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result transaction: %s", res_str(got_res));
        end else begin
          exp_res = pin_expect_q.pop_front();
          if (got_res !== exp_res) begin
            err_count++;
            if (err_count <= 10)
              $display("result mismatch\n  exp %s\n  got %s", res_str(exp_res), res_str(got_res));
          end
        end
      end
    end
  end

  // ---------------- receiver stalls ----------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 199);
      if (!idle_en || stall_roll < 150) stall_left = 0;
      else if (stall_roll < 197) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(8, 16);
    end
    out_stall <= (stall_left != 0);
  end

  // ---------------- stimulus ----------------
  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 199);
    if (r < 130) return 0;
    else if (r < 196) return $urandom_range(1, 3);
    else return $urandom_range(8, 16);
  endfunction

  function automatic logic [7:0] rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(1, CHANNELS));
    else if (r == 7) return 8'd0;
    else if (r == 8) return 8'($urandom_range(CHANNELS + 1, 255));
    else return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom_range(0, LVL_TOP));
    else if (r < 6) return 16'($urandom_range(LVL_TOP + 1, 65535));
    else if (r == 6) return 16'd0;
    else if (r == 7) return 16'(LVL_TOP);
    else if (r == 8) return 16'hFFFF;
    else return 16'($urandom);
  endfunction

  function automatic void add_row(row_kind_t k, cmd_t c, logic [7:0] ch, logic [15:0] lv,
                                  bit t, pin_result_t r);
    stim_row_t row;
    row.kind = k;
    row.cmd = c;
    row.chan = ch;
    row.lvl = lv;
    row.typed = t;
    row.res = r;
    stim_table.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(cmd_t c, logic [7:0] ch, logic [15:0] lv);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd <= c;
    in_channel <= ch;
    in_level <= lv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic drain_sequence();
    while (seq_phase != P_IDLE) send_item(CMD_TICK, rand_chan(), rand_level());
  endtask

  task automatic write_cfg(logic [2:0] v);
    in_valid <= 1'b0;
    do @(negedge clk); while (pin_expect_q.size() != 0);
    repeat (4) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cmd_items;
    int writes_left;
    int roll;

    for (int k = 0; k < N_WORDS; k++) lvl_store[k] = '0;
    seq_phase = P_IDLE;
    word_idx = 0;
    bit_idx = 0;
    gray_cnt = 0;
    pin_state = '0;
    drv_cfg = 3'(DRV_RESET);

    // result bits: rej busy gck blk mode lat dat sclk
    add_row(ROW_ITEM, CMD_TICK, 8'd0, 16'd0, 1, 8'b0000_0000);
    add_row(ROW_ITEM, CMD_SET, 8'd0, 16'd123, 1, 8'b1000_0000);
    add_row(ROW_ITEM, CMD_SET, 8'd17, 16'd4095, 1, 8'b1000_0000);
    add_row(ROW_ITEM, CMD_SET, 8'd255, 16'hFFFF, 1, 8'b1000_0000);
    add_row(ROW_ITEM, CMD_SET, 8'd1, 16'hFFFF, 1, 8'b0000_0000);
    add_row(ROW_ITEM, CMD_SET, 8'd16, 16'd4096, 1, 8'b0000_0000);
    add_row(ROW_ITEM, CMD_SET, 8'd8, 16'h0A5C, 0, '0);
    add_row(ROW_ITEM, CMD_SET, 8'd9, 16'h1FFF, 1, 8'b0000_0000);
    add_row(ROW_CFG, CMD_TICK, 8'd0, 16'd0, 0, '0);
    add_row(ROW_ITEM, CMD_SET, 8'd16, 16'd0, 1, 8'b0000_0000);
    add_row(ROW_ITEM, CMD_WRITE, 8'd0, 16'd0, 1, 8'b0100_0000);
    add_row(ROW_ITEM, CMD_DOTC, 8'd5, 16'd5, 0, '0);
    add_row(ROW_ITEM, CMD_SET, 8'd3, 16'd7, 0, '0);
    add_row(ROW_DRAIN, CMD_TICK, 8'd0, 16'd0, 0, '0);
    add_row(ROW_ITEM, CMD_TICK, 8'd0, 16'd0, 1, 8'b0001_0010);
    add_row(ROW_CFG, CMD_TICK, 8'd0, 16'd7, 0, '0);
    add_row(ROW_ITEM, CMD_DOTC, 8'd0, 16'd0, 1, 8'b0101_1010);
    add_row(ROW_ITEM, CMD_WRITE, 8'd0, 16'd0, 1, 8'b1101_1011);
    add_row(ROW_DRAIN, CMD_TICK, 8'd0, 16'd0, 0, '0);
    add_row(ROW_ITEM, CMD_TICK, 8'd0, 16'd0, 1, 8'b0001_1010);
    add_row(ROW_ITEM, CMD_WRITE, 8'd0, 16'd0, 0, '0);
    add_row(ROW_DRAIN, CMD_TICK, 8'd0, 16'd0, 0, '0);
    add_row(ROW_CFG, CMD_TICK, 8'd0, 16'd4, 0, '0);
    add_row(ROW_ITEM, CMD_SET, 8'd16, 16'h0FFF, 0, '0);
    add_row(ROW_ITEM, CMD_TICK, 8'hA5, 16'h5A5A, 0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_CFG: write_cfg(stim_table[i].lvl[2:0]);
        ROW_DRAIN: drain_sequence();
        default: begin
          typed_on = stim_table[i].typed;
          typed_res = stim_table[i].res;
          send_item(stim_table[i].cmd, stim_table[i].chan, stim_table[i].lvl);
          typed_on = 1'b0;
        end
      endcase
    end

    cmd_items = 0;
    writes_left = RAND_WRITES;
    while (cmd_items < N_RAND) begin
      if (seq_phase != P_IDLE) begin
        if ($urandom_range(0, 99) < 97) begin
          send_item(CMD_TICK, rand_chan(), rand_level());
        end else begin
          send_item(cmd_t'($urandom_range(1, 3)), rand_chan(), rand_level());
          cmd_items++;
        end
      end else begin
        roll = $urandom_range(0, 999);
        if (roll < 560) begin
          send_item(CMD_SET, rand_chan(), rand_level());
        end else if (roll < 760) begin
          send_item(CMD_TICK, rand_chan(), rand_level());
        end else if (roll < 860) begin
          idle_en <= ($urandom_range(0, 3) != 0);
          send_item(CMD_DOTC, rand_chan(), rand_level());
        end else if (roll < 870 && writes_left > 0) begin
          writes_left--;
          idle_en <= ($urandom_range(0, 3) != 0);
          send_item(CMD_WRITE, rand_chan(), rand_level());
        end else if (roll < 890) begin
          write_cfg(3'($urandom_range(0, 7)));
        end else if (roll < 900) begin
          // hold off until every pending result has drained
          in_valid <= 1'b0;
          do @(negedge clk); while (pin_expect_q.size() != 0);
        end else begin
          send_item(CMD_SET, rand_chan(), rand_level());
        end
        cmd_items++;
      end
    end
    drain_sequence();
    in_valid <= 1'b0;

    while (pin_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && pin_expect_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
